// File: rtl/core/fwi_pkg.sv
// ----------------------------------------------------------------------------
// fwi_pkg
// Shared types, constants and helpers of the fasta window indexer.
// ----------------------------------------------------------------------------
package fwi_pkg;

	localparam int CNT_W      = 32;
	localparam int LEN_W      = 16;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);
	localparam int STEP_W     = $clog2(CNT_W);
	localparam int OUT_W      = 4 * CNT_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

	localparam logic [LEN_W-1:0] LENGTH_RST = 16'd100;
	localparam logic [LEN_W-1:0] STRIDE_RST = 16'd100;

	// text characters
	localparam logic [BYTE_W-1:0] CH_MARK = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic [LEN_W-1:0] stride;
		logic [CNT_W-1:0] limit;
	} cfg_t;

	// one contig close handed from the parser to the back end
	typedef struct packed {
		logic [CNT_W-1:0] bases;
		logic             named;
		logic             eos;
		logic             chk;
	} cmd_t;

	// answer to a close that has to check the window limit
	typedef struct packed {
		logic valid;
		logic stop;
	} resp_t;

	function automatic logic is_ws(input logic [BYTE_W-1:0] b);
		is_ws = (b == CH_SP) || (b inside {[CH_TAB:CH_CR]});
	endfunction

endpackage

// File: rtl/core/fwi_queue.sv
// ----------------------------------------------------------------------------
// fwi_queue
// Small command queue between the parser and the window back end.
// ----------------------------------------------------------------------------
module fwi_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fwi_pkg::cmd_t  din,
	output logic           full,
	input  logic           pop,
	output fwi_pkg::cmd_t  dout,
	output logic           valid
);

	fwi_pkg::cmd_t                    entries_q [fwi_pkg::QDEPTH];
	logic [fwi_pkg::QPTR_W-1:0]       wr_q;
	logic [fwi_pkg::QPTR_W-1:0]       rd_q;
	logic [fwi_pkg::QCNT_W-1:0]       cnt_q;

	assign full  = (cnt_q == fwi_pkg::QCNT_W'(fwi_pkg::QDEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = entries_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("queue read while empty");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop && !full |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count lost a write");
`endif

endmodule

// File: rtl/core/fwi_front.sv
// ----------------------------------------------------------------------------
// fwi_front
// Text parser: tracks lines, headers and names, counts bases and queues
// contig closes for the back end.
// ----------------------------------------------------------------------------
module fwi_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fwi_pkg::BYTE_W-1:0]  in_byte,
	input  logic                        in_eos,
	input  logic                        limit_on,
	output logic                        push,
	output fwi_pkg::cmd_t               cmd,
	input  logic                        full,
	input  fwi_pkg::resp_t              resp
);

	typedef enum logic [2:0] {
		F_RUN  = 3'b001,
		F_WAIT = 3'b010,
		F_STOP = 3'b100
	} fstate_t;

	fstate_t                     state_q;
	logic [fwi_pkg::CNT_W-1:0]   bases_q;
	logic                        bol_q;
	logic                        inh_q;
	logic                        jam_q;
	logic                        name_q;

	logic                        take;
	logic                        name_now;
	logic                        is_hdr;
	logic [fwi_pkg::CNT_W-1:0]   bases_inc;

	always_comb begin
		in_ready  = ((state_q == F_RUN) && !full) || (state_q == F_STOP);
		take      = in_valid && in_ready && (state_q == F_RUN);
		// byte right after the marker decides whether the name is empty
		name_now  = jam_q ? !((in_byte == fwi_pkg::CH_SP) || (in_byte == fwi_pkg::CH_TAB) ||
			(in_byte == fwi_pkg::CH_LF)) : name_q;
		is_hdr    = !in_eos && bol_q && (in_byte == fwi_pkg::CH_MARK);
		push      = take && (in_eos || (is_hdr && (name_now || limit_on)));
		cmd.bases = bases_q;
		cmd.named = in_eos ? name_q : name_now;
		cmd.eos   = in_eos;
		cmd.chk   = !in_eos && limit_on;
		bases_inc = (bases_q == '1) ? bases_q : bases_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_RUN;
			bases_q <= '0;
			bol_q   <= 1'b1;
			inh_q   <= 1'b0;
			jam_q   <= 1'b0;
			name_q  <= 1'b0;
		end else begin
			case (state_q)
				F_RUN: begin
					if (take) begin
						if (in_eos) begin
							state_q <= F_STOP;
						end else begin
							if (jam_q) begin
								jam_q  <= 1'b0;
								name_q <= name_now;
							end
							if (in_byte == fwi_pkg::CH_LF) begin
								bol_q <= 1'b1;
								inh_q <= 1'b0;
							end else if (is_hdr) begin
								bol_q  <= 1'b0;
								inh_q  <= 1'b1;
								jam_q  <= 1'b1;
								name_q <= 1'b0;
								// unnamed contigs keep their bases for the next one
								if (name_now) begin
									bases_q <= '0;
								end
								if (limit_on) begin
									state_q <= F_WAIT;
								end
							end else begin
								bol_q <= 1'b0;
								if (!inh_q && !fwi_pkg::is_ws(in_byte)) begin
									bases_q <= bases_inc;
								end
							end
						end
					end
				end
				F_WAIT: begin
					if (resp.valid) begin
						state_q <= resp.stop ? F_STOP : F_RUN;
					end
				end
				F_STOP: begin
					state_q <= F_STOP;
				end
				default: begin
					state_q <= F_RUN;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_stop_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_STOP |=> state_q == F_STOP)
		else $error("parser left the stopped state");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("close queued into a full queue");

	a_wait_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_WAIT && !resp.valid |=> state_q == F_WAIT)
		else $error("limit wait ended without an answer");
`endif

endmodule

// File: rtl/core/fwi_back.sv
// ----------------------------------------------------------------------------
// fwi_back
// Window back end: divides, clamps to the limit, keeps the running window
// and contig totals and drives the result register.
// ----------------------------------------------------------------------------
module fwi_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fwi_pkg::cfg_t              cfg,
	input  logic                       cmd_valid,
	input  fwi_pkg::cmd_t              cmd_in,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [fwi_pkg::OUT_W-1:0]  out_data,
	output logic                       out_record,
	output logic                       out_final,
	output fwi_pkg::resp_t             resp
);

	typedef enum logic [5:0] {
		B_IDLE  = 6'b000001,
		B_DIV   = 6'b000010,
		B_CNT   = 6'b000100,
		B_CLAMP = 6'b001000,
		B_SUM   = 6'b010000,
		B_EMIT  = 6'b100000
	} bstate_t;

	localparam int CW = fwi_pkg::CNT_W;
	localparam int LW = fwi_pkg::LEN_W;

	bstate_t                      state_q;
	fwi_pkg::cmd_t                cmd_q;
	logic                         ge_q;
	logic [CW-1:0]                dq_q;
	logic [LW:0]                  rem_q;
	logic [fwi_pkg::STEP_W-1:0]   step_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                sum_q;
	logic [CW-1:0]                win_q;
	logic [CW-1:0]                ctg_q;
	logic                         ov_q;
	logic [fwi_pkg::OUT_W-1:0]    od_q;
	logic                         orec_q;
	logic                         ofin_q;

	logic [LW-1:0]                stride_eff;
	logic [LW:0]                  rem_sh;
	logic                         fits;
	logic                         in_ge;
	logic [CW-1:0]                rem_lim;
	logic [CW:0]                  sum_w;
	logic                         stop;
	logic                         emit;
	logic                         go;

	always_comb begin
		stride_eff = (cfg.stride == '0) ? LW'(1) : cfg.stride;
		rem_sh     = {rem_q[LW-1:0], dq_q[CW-1]};
		fits       = (rem_sh >= {1'b0, stride_eff});
		in_ge      = (cmd_in.bases >= CW'(cfg.length));
		rem_lim    = (cfg.limit > win_q) ? cfg.limit - win_q : '0;
		sum_w      = {1'b0, win_q} + {1'b0, cnt_q};
		stop       = cmd_q.chk && (cfg.limit != '0) && (sum_q >= cfg.limit);
		emit       = cmd_q.named || cmd_q.eos || stop;
		go         = (state_q == B_EMIT) && (!ov_q || out_ready);
		pop        = (state_q == B_IDLE) && cmd_valid;
		resp.valid = go && cmd_q.chk;
		resp.stop  = stop;
		out_valid  = ov_q;
		out_data   = od_q;
		out_record = orec_q;
		out_final  = ofin_q;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop) begin
					cmd_q  <= cmd_in;
					ge_q   <= cmd_in.named && in_ge;
					dq_q   <= cmd_in.bases - CW'(cfg.length);
					rem_q  <= '0;
					step_q <= '0;
				end
			end
			B_DIV: begin
				// one quotient bit per cycle, restoring
				rem_q  <= fits ? rem_sh - {1'b0, stride_eff} : rem_sh;
				dq_q   <= {dq_q[CW-2:0], fits};
				step_q <= step_q + 1'b1;
			end
			B_CNT: begin
				cnt_q <= !ge_q ? '0 : ((dq_q == '1) ? dq_q : dq_q + 1'b1);
			end
			B_CLAMP: begin
				if ((cfg.limit != '0) && (cnt_q > rem_lim)) begin
					cnt_q <= rem_lim;
				end
			end
			B_SUM: begin
				sum_q <= sum_w[CW] ? '1 : sum_w[CW-1:0];
			end
			B_EMIT: begin
				if (go && emit) begin
					od_q   <= cmd_q.named ? {cmd_q.bases, cnt_q, win_q, ctg_q} : '0;
					orec_q <= cmd_q.named;
					ofin_q <= cmd_q.eos || stop;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			win_q   <= '0;
			ctg_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= (cmd_in.named && in_ge) ? B_DIV : B_CNT;
					end
				end
				B_DIV: begin
					if (step_q == '1) begin
						state_q <= B_CNT;
					end
				end
				B_CNT: begin
					state_q <= B_CLAMP;
				end
				B_CLAMP: begin
					state_q <= B_SUM;
				end
				B_SUM: begin
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (go) begin
						state_q <= B_IDLE;
						if (emit) begin
							ov_q <= 1'b1;
						end
						if (cmd_q.named) begin
							win_q <= sum_q;
							ctg_q <= (ctg_q == '1) ? ctg_q : ctg_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV && step_q == '1 |=> state_q == B_CNT)
		else $error("divider ran past its last step");

	a_pop_start: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == B_DIV || state_q == B_CNT)
		else $error("popped close did not start");

	a_blank_result: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !orec_q |-> od_q == '0 && ofin_q)
		else $error("result without record is not blank and final");
`endif

endmodule

// File: rtl/core/fasta_window_indexer.sv
// ----------------------------------------------------------------------------
// fasta_window_indexer
// FASTA text in, one record per named contig out: contig number, first
// window id, window count and base count.
// ----------------------------------------------------------------------------
//  channel   dir  signals                        content
//  s_*       in   s_tvalid s_tready s_tdata      text byte, tlast = end of stream
//                 s_tlast
//  m_*       out  m_tvalid m_tready m_tdata      contig record, tuser = has record,
//                 m_tuser m_tlast                tlast = final result
//  cfg_*     in   cfg_we cfg_index cfg_data      window length, stride, limit
//
// text bytes are taken one per cycle; a header while the window limit is
// nonzero holds s_tready low until the back end has closed that contig
// a named contig that reaches the window length runs through the serial divider
// in the back end, a shorter or unnamed one skips it;
// the queue holds 4 closes, and s_tready drops while it is full
// reset clears all counts and loads length 100, stride 100, no limit
// m_tready low with a result pending holds the back end in emit, filling the queue
// ----------------------------------------------------------------------------
module fasta_window_indexer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // data_byte
	input  logic                              s_tlast,   // end_of_stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// contig number, first window id, windows in contig, base count
	output logic [fwi_pkg::OUT_W-1:0]         m_tdata,
	output logic                              m_tuser,   // has_record
	output logic                              m_tlast,   // is_final
	input  logic                              cfg_we,
	input  logic [fwi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fwi_pkg::CFG_DATA_W-1:0]    cfg_data
);

	fwi_pkg::cfg_t   cfg_q;
	fwi_pkg::cmd_t   q_din;
	fwi_pkg::cmd_t   q_dout;
	fwi_pkg::resp_t  resp;
	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.length <= fwi_pkg::LENGTH_RST;
			cfg_q.stride <= fwi_pkg::STRIDE_RST;
			cfg_q.limit  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				fwi_pkg::REG_LENGTH: cfg_q.length <= cfg_data[fwi_pkg::LEN_W-1:0];
				fwi_pkg::REG_STRIDE: cfg_q.stride <= cfg_data[fwi_pkg::LEN_W-1:0];
				fwi_pkg::REG_LIMIT:  cfg_q.limit  <= cfg_data[fwi_pkg::CNT_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	fwi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_eos   (s_tlast),
		.limit_on (cfg_q.limit != '0),
		.push     (q_push),
		.cmd      (q_din),
		.full     (q_full),
		.resp     (resp)
	);

	fwi_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.valid  (q_valid)
	);

	fwi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd_valid  (q_valid),
		.cmd_in     (q_dout),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_record (m_tuser),
		.out_final  (m_tlast),
		.resp       (resp)
	);

endmodule

// File: test/tb_fasta_window_indexer.sv
// ----------------------------------------------------------------------------
// tb_fasta_window_indexer
// Streams FASTA text through the indexer and checks every contig record.
// A behavioral copy of the parser and window arithmetic predicts each result
// at the moment its text item is accepted. The run walks through several
// window settings, including the zero and full-scale ones, and ends either
// at end of stream or at a window-limit stop, then checks that later items
// are ignored.
// ----------------------------------------------------------------------------
module tb_fasta_window_indexer;

	typedef struct {
		logic        rec;
		logic [31:0] num;
		logic [31:0] first;
		logic [31:0] cnt;
		logic [31:0] bases;
		logic        fin;
	} contig_rec_t;

	class contig_scoreboard;
		logic [fwi_pkg::LEN_W-1:0] win_len;
		logic [fwi_pkg::LEN_W-1:0] win_step;
		logic [31:0]      win_limit;
		logic [31:0]      bases;
		logic [31:0]      windows;
		logic [31:0]      contigs;
		logic             line_start;
		logic             in_hdr;
		logic             after_mark;
		logic             named;
		logic             halted;
		contig_rec_t      pending[$];
		int               errors;

		function new();
			win_len    = fwi_pkg::LENGTH_RST;
			win_step   = fwi_pkg::STRIDE_RST;
			win_limit  = '0;
			bases      = '0;
			windows    = '0;
			contigs    = '0;
			line_start = 1'b1;
			in_hdr     = 1'b0;
			after_mark = 1'b0;
			named      = 1'b0;
			halted     = 1'b0;
			errors     = 0;
		endfunction

		function logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[32] ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		function logic blank(input logic [7:0] b);
			return (b == fwi_pkg::CH_SP) || (b >= fwi_pkg::CH_TAB && b <= fwi_pkg::CH_CR);
		endfunction

		// closes the open contig; a contig with an empty name leaves its bases in place
		function contig_rec_t close_contig(input logic fin);
			contig_rec_t r;
			logic [31:0] step;
			logic [31:0] cnt;
			logic [31:0] room;
			r = '{default: '0};
			r.fin = fin;
			if (named) begin
				step = (win_step == 0) ? 32'd1 : {16'd0, win_step};
				cnt = '0;
				if (bases >= {16'd0, win_len})
					cnt = sat_add((bases - {16'd0, win_len}) / step, 32'd1);
				if (win_limit != 0) begin
					room = (win_limit > windows) ? win_limit - windows : 32'd0;
					if (cnt > room)
						cnt = room;
				end
				r.rec   = 1'b1;
				r.num   = contigs;
				r.first = windows;
				r.cnt   = cnt;
				r.bases = bases;
				windows = sat_add(windows, cnt);
				contigs = sat_add(contigs, 32'd1);
				bases   = '0;
				named   = 1'b0;
			end
			return r;
		endfunction

		function void note_text(input logic [7:0] b, input logic eos);
			contig_rec_t r;
			if (halted) begin
			end else if (eos) begin
				pending.insert(pending.size(), close_contig(1'b1));
				halted = 1'b1;
			end else begin
				if (after_mark) begin
					after_mark = 1'b0;
					named = !(b == fwi_pkg::CH_SP || b == fwi_pkg::CH_TAB ||
						b == fwi_pkg::CH_LF);
				end
				if (b == fwi_pkg::CH_LF) begin
					line_start = 1'b1;
					in_hdr     = 1'b0;
				end else if (line_start && b == fwi_pkg::CH_MARK) begin
					line_start = 1'b0;
					r = close_contig(1'b0);
					if (win_limit != 0 && windows >= win_limit) begin
						r.fin = 1'b1;
						pending.insert(pending.size(), r);
						halted = 1'b1;
					end else begin
						in_hdr     = 1'b1;
						after_mark = 1'b1;
						named      = 1'b0;
						if (r.rec)
							pending.insert(pending.size(), r);
					end
				end else begin
					line_start = 1'b0;
					if (!in_hdr && !blank(b))
						bases = sat_add(bases, 32'd1);
				end
			end
		endfunction

		task report(input string what, input logic [31:0] got, input logic [31:0] want);
			errors++;
			$display("mismatch: %s got %0h want %0h", what, got, want);
		endtask

		task check_record(input logic has_rec, input logic [fwi_pkg::OUT_W-1:0] word,
				input logic fin);
			contig_rec_t want;
			if (pending.size() == 0) begin
				report("record with nothing pending", {31'd0, has_rec}, 32'd0);
			end else begin
				want = pending.pop_front();
				if (has_rec !== want.rec)
					report("has_record", {31'd0, has_rec}, {31'd0, want.rec});
				if (word[31:0] !== want.num)
					report("contig_number", word[31:0], want.num);
				if (word[63:32] !== want.first)
					report("first_window", word[63:32], want.first);
				if (word[95:64] !== want.cnt)
					report("win_count", word[95:64], want.cnt);
				if (word[127:96] !== want.bases)
					report("base_count", word[127:96], want.bases);
				if (fin !== want.fin)
					report("is_final", {31'd0, fin}, {31'd0, want.fin});
			end
		endtask
	endclass

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata   = '0;
	logic                           s_tlast   = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b1;
	logic [fwi_pkg::OUT_W-1:0]      m_tdata;
	logic                           m_tuser;
	logic                           m_tlast;
	logic                           cfg_we    = 1'b0;
	logic [fwi_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [fwi_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	contig_scoreboard sb = new();
	logic [7:0] last_sent = fwi_pkg::CH_LF;
	int         sent_items = 0;
	logic       calm = 1'b0;
	logic       quiet = 1'b0;

	fasta_window_indexer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_text(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				sb.check_record(m_tuser, m_tdata, m_tlast);
		end
	end

	// receiver backpressure in bursts
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		#5_000_000;
		$display("fasta_window_indexer regression: fail");
		$finish;
	end

	task automatic push_text(input logic [7:0] b, input logic eos);
		if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eos;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		last_sent = b;
		sent_items++;
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			push_text(s[i], 1'b0);
	endtask

	task automatic write_reg(input logic [fwi_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			fwi_pkg::REG_LENGTH: sb.win_len   = val[fwi_pkg::LEN_W-1:0];
			fwi_pkg::REG_STRIDE: sb.win_step  = val[fwi_pkg::LEN_W-1:0];
			fwi_pkg::REG_LIMIT:  sb.win_limit = val;
			default: ;
		endcase
	endtask

	task automatic set_windows(input logic [15:0] len, input logic [15:0] step,
			input logic [31:0] lim);
		write_reg(fwi_pkg::REG_LENGTH, {16'd0, len});
		write_reg(fwi_pkg::REG_STRIDE, {16'd0, step});
		write_reg(fwi_pkg::REG_LIMIT, lim);
	endtask

	// drain: closes with no record may still sit in the back end queue
	task automatic drain(input int extra);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	function automatic logic [7:0] text_byte();
		string letters;
		int r;
		letters = "ACGTNacgtn";
		r = $urandom_range(0, 99);
		if (r < 80)
			return letters[$urandom_range(0, 9)];
		else if (r < 84)
			return fwi_pkg::CH_SP;
		else if (r < 88)
			return 8'($urandom_range(9, 13));
		else
			return 8'($urandom_range(0, 255));
	endfunction

	task automatic emit_contig();
		int span;
		int nlines;
		logic [7:0] c;
		if (last_sent != fwi_pkg::CH_LF)
			push_text(fwi_pkg::CH_LF, 1'b0);
		if ($urandom_range(0, 9) == 0) begin
			// broken text: stray markers and newlines anywhere
			span = $urandom_range(5, 30);
			for (int k = 0; k < span; k++) begin
				c = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 5) == 0)
					c = fwi_pkg::CH_MARK;
				push_text(c, 1'b0);
			end
		end else begin
			push_text(fwi_pkg::CH_MARK, 1'b0);
			case ($urandom_range(0, 9))
				0: push_text(fwi_pkg::CH_SP, 1'b0);
				1: push_text(fwi_pkg::CH_TAB, 1'b0);
				2: push_text(fwi_pkg::CH_LF, 1'b0);
				default: push_text(8'($urandom_range(33, 126)), 1'b0);
			endcase
			if (last_sent != fwi_pkg::CH_LF) begin
				span = $urandom_range(0, 6);
				for (int k = 0; k < span; k++)
					push_text(8'($urandom_range(32, 126)), 1'b0);
				push_text(fwi_pkg::CH_LF, 1'b0);
			end
			nlines = $urandom_range(0, 4);
			for (int k = 0; k < nlines; k++) begin
				span = ($urandom_range(0, 19) == 0) ? $urandom_range(26, 200)
					: $urandom_range(0, 25);
				for (int j = 0; j < span; j++)
					push_text(text_byte(), 1'b0);
				if ($urandom_range(0, 3) == 0)
					push_text(fwi_pkg::CH_CR, 1'b0);
				push_text(fwi_pkg::CH_LF, 1'b0);
			end
		end
	endtask

	initial begin
		int phase_start;
		int mode;
		int k;
		logic [15:0] len;
		logic [15:0] step;
		logic [31:0] lim;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: bases ahead of the first header, empty names, odd bytes
		push_str("AC\t");
		push_text(8'hFF, 1'b0);
		push_text(8'h00, 1'b0);
		push_str("\n>\nT \n> x\n>\tq\n>id\nG>\r\n>z\n");
		drain(250);

		for (int p = 0; p < 12; p++) begin
			case (p)
				0: set_windows(16'd1, 16'd1, 32'd0);
				1: set_windows(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
				2: set_windows(16'd0, 16'd0, 32'd0);
				3: set_windows(16'd1, 16'hFFFF, sb.windows + 32'h0010_0000);
				4: set_windows(16'hFFFF, 16'd1, 32'd0);
				default: begin
					len  = ($urandom_range(0, 9) == 0) ? 16'd0
						: 16'($urandom_range(1, 40));
					step = ($urandom_range(0, 9) == 0) ? 16'd0
						: 16'($urandom_range(1, 12));
					lim  = ($urandom_range(0, 1) == 0) ? 32'd0
						: sb.windows + 32'h0010_0000 + $urandom_range(0, 32'h0FFF_FFFF);
					set_windows(len, step, lim);
				end
			endcase
			calm = ($urandom_range(0, 3) == 0);
			phase_start = sent_items;
			while (sent_items - phase_start < 130)
				emit_contig();
			drain(250);
		end

		// closing part: end of stream or a window-limit stop
		calm  = 1'b0;
		quiet = 1'b1;
		mode  = $urandom_range(0, 2);
		if (mode == 2 && sb.windows < 2)
			mode = 1;
		k = 0;
		case (mode)
			0: begin
				phase_start = sent_items;
				while (sent_items - phase_start < 100)
					emit_contig();
				if ($urandom_range(0, 1) == 0) begin
					// header with nothing after it
					if (last_sent != fwi_pkg::CH_LF)
						push_text(fwi_pkg::CH_LF, 1'b0);
					push_text(fwi_pkg::CH_MARK, 1'b0);
				end
			end
			1: begin
				set_windows(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
					sb.windows + $urandom_range(1, 40));
				while (!sb.halted && k < 300) begin
					emit_contig();
					k++;
				end
			end
			default: begin
				// limit below the windows already given
				write_reg(fwi_pkg::REG_LIMIT, $urandom_range(1, sb.windows - 1));
				while (!sb.halted && k < 50) begin
					emit_contig();
					k++;
				end
			end
		endcase
		if (!sb.halted)
			push_text(8'($urandom_range(0, 255)), 1'b1);
		// everything from here on is ignored
		repeat (3) push_text(8'($urandom_range(0, 255)), 1'b0);
		push_text(8'($urandom_range(0, 255)), 1'b1);
		drain(300);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("fasta_window_indexer regression: pass");
		else
			$display("fasta_window_indexer regression: fail");
		$finish;
	end

endmodule
